### hw/rtl/psa_msa_pkg.sv
// Shared types and constants of the mask scatter address generator.
package psa_msa_pkg;

    localparam int ADDR_W  = 5;
    localparam int SIZE_W  = 7;
    localparam int HALF_W  = 6;
    localparam int IDX_W   = 32;
    localparam int DST_W   = 30;
    localparam int VAL_W   = 32;
    localparam int TDATA_W = 96;

    typedef enum logic [2:0] {
        REG_MODE           = 3'd0,
        REG_BATCH_COUNT    = 3'd1,
        REG_FEATURE_ROWS   = 3'd2,
        REG_FEATURE_COLS   = 3'd3,
        REG_MASK_ROWS      = 3'd4,
        REG_MASK_COLS      = 3'd5,
        REG_HALF_MASK_ROWS = 3'd6,
        REG_HALF_MASK_COLS = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } t_state;

    // Effective sizes, clamped to their legal ranges.
    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] nb;
        logic [SIZE_W-1:0] fh;
        logic [SIZE_W-1:0] fw;
        logic [SIZE_W-1:0] mh;
        logic [SIZE_W-1:0] mw;
        logic [HALF_W-1:0] hmr;
        logic [HALF_W-1:0] hmc;
    } t_cfg;

endpackage

### hw/rtl/psa_mask_scatter_address.sv
// Top level of the mask scatter address generator.
// Each mask element transfer is handled in turn: it is accepted in ST_IDLE, makes eight passes through the single
// 32x7 multiply-add unit in ST_CALC (four for the source index, four for the destination index), and
// loads the output register in ST_DONE, which waits while that register is full and not taken; the next element
// is accepted in the cycle after that, and no element is accepted while one is still being processed.
module psa_mask_scatter_address #(
    parameter int MAX_FEATURE = 64,
    parameter int MAX_BATCH   = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psa_msa_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // value[31:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // value_out[31:0], src_index[63:32], dst_index[93:64], zero pad[95:94]
    output logic [psa_msa_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    output logic [0:0]                      m_axis_tuser   // in_window[0]
);

    localparam int FPW = (MAX_FEATURE > 1) ? $clog2(MAX_FEATURE) : 1;
    localparam int BPW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int AW  = (FPW > 7) ? FPW : 7;
    localparam int SW  = AW + 1;
    localparam logic [31:0] VMASK = (DATA_WIDTH >= 32) ? 32'hFFFF_FFFF
                                  : 32'((64'd1 << DATA_WIDTH) - 64'd1);

    psa_msa_pkg::t_cfg   cfg;
    psa_msa_pkg::t_state r_state, n_state;

    logic           accept, mac_en, mac_first, load_out;
    logic [6:0]     mac_mult;
    logic [AW-1:0]  mac_add;
    logic [31:0]    acc;
    logic [2:0]     r_step;

    logic [BPW-1:0] cnt_n;
    logic [6:0]     cnt_mr, cnt_mc;
    logic [FPW-1:0] cnt_h, cnt_w;
    logic           cnt_last;

    logic [SW-1:0]  sr, sc, row_full, col_full;
    logic           win_hit;

    logic [BPW-1:0] r_n;
    logic [6:0]     r_mr, r_mc, r_row, r_col;
    logic [FPW-1:0] r_h, r_w;
    logic           r_inside, r_last;
    logic [31:0]    r_value, r_src;

    logic                            r_out_valid;
    logic [psa_msa_pkg::TDATA_W-1:0] r_tdata;
    logic                            r_tlast;
    logic                            r_tuser;

    psa_msa_cfg #(
        .MAX_FEATURE(MAX_FEATURE),
        .MAX_BATCH  (MAX_BATCH)
    ) u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (psel && penable && pwrite),
        .i_addr (paddr),
        .i_wdata(pwdata),
        .o_rdata(prdata),
        .o_cfg  (cfg)
    );

    assign pready = 1'b1;

    psa_msa_cnt #(
        .FPW(FPW),
        .BPW(BPW)
    ) u_cnt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (accept),
        .i_cfg  (cfg),
        .o_n    (cnt_n),
        .o_mr   (cnt_mr),
        .o_mc   (cnt_mc),
        .o_h    (cnt_h),
        .o_w    (cnt_w),
        .o_last (cnt_last)
    );

    psa_msa_mac #(
        .ADD_W(AW)
    ) u_mac (
        .i_clk  (i_clk),
        .i_en   (mac_en),
        .i_first(mac_first),
        .i_seed (32'(r_n)),
        .i_mult (mac_mult),
        .i_add  (mac_add),
        .o_acc  (acc)
    );

    assign accept = s_axis_tvalid && s_axis_tready;

    assign sr       = SW'(cnt_mr) + SW'(cnt_h);
    assign sc       = SW'(cnt_mc) + SW'(cnt_w);
    assign row_full = sr - SW'(cfg.hmr);
    assign col_full = sc - SW'(cfg.hmc);
    assign win_hit  = (sr >= SW'(cfg.hmr)) && (row_full < SW'(cfg.fh))
                   && (sc >= SW'(cfg.hmc)) && (col_full < SW'(cfg.fw));

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n      <= cnt_n;
            r_mr     <= cnt_mr;
            r_mc     <= cnt_mc;
            r_h      <= cnt_h;
            r_w      <= cnt_w;
            r_row    <= row_full[6:0];
            r_col    <= col_full[6:0];
            r_inside <= win_hit;
            r_last   <= cnt_last;
            r_value  <= s_axis_tdata & VMASK;
        end
        if (r_state == psa_msa_pkg::ST_CALC && r_step == 3'd4) begin
            r_src <= acc;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psa_msa_pkg::ST_IDLE: if (accept) n_state = psa_msa_pkg::ST_CALC;
            psa_msa_pkg::ST_CALC: if (r_step == 3'd7) n_state = psa_msa_pkg::ST_DONE;
            psa_msa_pkg::ST_DONE: if (load_out) n_state = psa_msa_pkg::ST_IDLE;
            default:              n_state = psa_msa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        mac_en        = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            psa_msa_pkg::ST_IDLE: s_axis_tready = 1'b1;
            psa_msa_pkg::ST_CALC: mac_en = 1'b1;
            psa_msa_pkg::ST_DONE: load_out = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    // Source chain first, then the destination chain, whose digit order follows the mode.
    always_comb begin
        mac_first = (r_step == 3'd0) || (r_step == 3'd4);
        mac_mult  = r_step[0] ? cfg.fw : cfg.fh;
        mac_add   = AW'(r_w);
        case (r_step)
            3'd0: begin
                mac_mult = cfg.mh;
                mac_add  = AW'(r_mr);
            end
            3'd1: begin
                mac_mult = cfg.mw;
                mac_add  = AW'(r_mc);
            end
            3'd2: mac_add = AW'(r_h);
            3'd3: mac_add = AW'(r_w);
            3'd4: mac_add = cfg.mode ? AW'(r_h) : AW'(r_row);
            3'd5: mac_add = cfg.mode ? AW'(r_w) : AW'(r_col);
            3'd6: mac_add = cfg.mode ? AW'(r_row) : AW'(r_h);
            3'd7: mac_add = cfg.mode ? AW'(r_col) : AW'(r_w);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psa_msa_pkg::ST_IDLE;
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == psa_msa_pkg::ST_CALC) begin
                r_step <= r_step + 3'd1;
            end else begin
                r_step <= 3'd0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_tdata <= {2'b00,
                        r_inside ? acc[psa_msa_pkg::DST_W-1:0] : 30'd0,
                        r_src,
                        r_inside ? r_value : 32'd0};
            r_tlast <= r_last;
            r_tuser <= r_inside;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_tdata;
    assign m_axis_tlast    = r_tlast;
    assign m_axis_tuser[0] = r_tuser;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input accepted while an element is still being processed.");

    a_step_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == psa_msa_pkg::ST_CALC && r_step != 3'd7
        |=> r_state == psa_msa_pkg::ST_CALC && r_step == $past(r_step) + 3'd1)
        else $error("Multiply-add sequence did not advance by one step.");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0]
        |-> m_axis_tdata[93:64] == 30'd0 && m_axis_tdata[31:0] == 32'd0)
        else $error("Element outside the window carries a value or destination.");

endmodule

### hw/rtl/psa_msa_cfg.sv
// Configuration register file with APB write and read access.
module psa_msa_cfg #(
    parameter int MAX_FEATURE = 64,
    parameter int MAX_BATCH   = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [psa_msa_pkg::ADDR_W-1:0]   i_addr,
    input  logic [31:0]                      i_wdata,
    output logic [31:0]                      o_rdata,
    output psa_msa_pkg::t_cfg                o_cfg
);

    localparam logic [10:0] MAXF = 11'(MAX_FEATURE);
    localparam logic [10:0] MAXB = 11'(MAX_BATCH);

    logic       r_mode;
    logic [6:0] r_batch_count;
    logic [6:0] r_feature_rows;
    logic [6:0] r_feature_cols;
    logic [6:0] r_mask_rows;
    logic [6:0] r_mask_cols;
    logic [5:0] r_half_mask_rows;
    logic [5:0] r_half_mask_cols;

    psa_msa_pkg::t_reg_idx idx;

    assign idx = psa_msa_pkg::t_reg_idx'(i_addr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= 1'b0;
            r_batch_count    <= 7'd1;
            r_feature_rows   <= 7'd1;
            r_feature_cols   <= 7'd1;
            r_mask_rows      <= 7'd1;
            r_mask_cols      <= 7'd1;
            r_half_mask_rows <= 6'd0;
            r_half_mask_cols <= 6'd0;
        end else if (i_wr) begin
            unique case (idx)
                psa_msa_pkg::REG_MODE:           r_mode           <= i_wdata[0];
                psa_msa_pkg::REG_BATCH_COUNT:    r_batch_count    <= i_wdata[6:0];
                psa_msa_pkg::REG_FEATURE_ROWS:   r_feature_rows   <= i_wdata[6:0];
                psa_msa_pkg::REG_FEATURE_COLS:   r_feature_cols   <= i_wdata[6:0];
                psa_msa_pkg::REG_MASK_ROWS:      r_mask_rows      <= i_wdata[6:0];
                psa_msa_pkg::REG_MASK_COLS:      r_mask_cols      <= i_wdata[6:0];
                psa_msa_pkg::REG_HALF_MASK_ROWS: r_half_mask_rows <= i_wdata[5:0];
                psa_msa_pkg::REG_HALF_MASK_COLS: r_half_mask_cols <= i_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_rdata = 32'd0;
        unique case (idx)
            psa_msa_pkg::REG_MODE:           o_rdata = {31'd0, r_mode};
            psa_msa_pkg::REG_BATCH_COUNT:    o_rdata = {25'd0, r_batch_count};
            psa_msa_pkg::REG_FEATURE_ROWS:   o_rdata = {25'd0, r_feature_rows};
            psa_msa_pkg::REG_FEATURE_COLS:   o_rdata = {25'd0, r_feature_cols};
            psa_msa_pkg::REG_MASK_ROWS:      o_rdata = {25'd0, r_mask_rows};
            psa_msa_pkg::REG_MASK_COLS:      o_rdata = {25'd0, r_mask_cols};
            psa_msa_pkg::REG_HALF_MASK_ROWS: o_rdata = {26'd0, r_half_mask_rows};
            psa_msa_pkg::REG_HALF_MASK_COLS: o_rdata = {26'd0, r_half_mask_cols};
            default:                         o_rdata = 32'd0;
        endcase
    end

    // A size of zero acts as one, and sizes above the maximum saturate.
    function automatic logic [6:0] clamp(input logic [6:0] v, input logic [10:0] maxv);
        logic [6:0] res;
        if (v == 7'd0) begin
            res = 7'd1;
        end else if ({4'd0, v} > maxv) begin
            res = maxv[6:0];
        end else begin
            res = v;
        end
        return res;
    endfunction

    always_comb begin
        o_cfg.mode = r_mode;
        o_cfg.nb   = clamp(r_batch_count, MAXB);
        o_cfg.fh   = clamp(r_feature_rows, MAXF);
        o_cfg.fw   = clamp(r_feature_cols, MAXF);
        o_cfg.mh   = clamp(r_mask_rows, 11'd127);
        o_cfg.mw   = clamp(r_mask_cols, 11'd127);
        o_cfg.hmr  = r_half_mask_rows;
        o_cfg.hmc  = r_half_mask_cols;
    end

endmodule

### hw/rtl/psa_msa_cnt.sv
// Position counters for batch, mask row, mask column, pixel row and pixel column.
module psa_msa_cnt #(
    parameter int FPW = 6,
    parameter int BPW = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  psa_msa_pkg::t_cfg i_cfg,
    output logic [BPW-1:0]    o_n,
    output logic [6:0]        o_mr,
    output logic [6:0]        o_mc,
    output logic [FPW-1:0]    o_h,
    output logic [FPW-1:0]    o_w,
    output logic              o_last
);

    logic [BPW-1:0] r_n, n_n;
    logic [6:0]     r_mr, n_mr, r_mc, n_mc;
    logic [FPW-1:0] r_h, n_h, r_w, n_w;
    logic           end_n, end_mr, end_mc, end_h, end_w;

    assign end_n  = (11'(r_n) + 11'd1)  >= 11'(i_cfg.nb);
    assign end_mr = (11'(r_mr) + 11'd1) >= 11'(i_cfg.mh);
    assign end_mc = (11'(r_mc) + 11'd1) >= 11'(i_cfg.mw);
    assign end_h  = (11'(r_h) + 11'd1)  >= 11'(i_cfg.fh);
    assign end_w  = (11'(r_w) + 11'd1)  >= 11'(i_cfg.fw);

    assign o_last = end_n && end_mr && end_mc && end_h && end_w;

    always_comb begin
        n_w  = end_w ? '0 : r_w + FPW'(1);
        n_h  = r_h;
        n_mc = r_mc;
        n_mr = r_mr;
        n_n  = r_n;
        if (end_w) begin
            n_h = end_h ? '0 : r_h + FPW'(1);
            if (end_h) begin
                n_mc = end_mc ? 7'd0 : r_mc + 7'd1;
                if (end_mc) begin
                    n_mr = end_mr ? 7'd0 : r_mr + 7'd1;
                    if (end_mr) begin
                        n_n = end_n ? '0 : r_n + BPW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n  <= '0;
            r_mr <= 7'd0;
            r_mc <= 7'd0;
            r_h  <= '0;
            r_w  <= '0;
        end else if (i_adv) begin
            r_n  <= n_n;
            r_mr <= n_mr;
            r_mc <= n_mc;
            r_h  <= n_h;
            r_w  <= n_w;
        end
    end

    assign o_n  = r_n;
    assign o_mr = r_mr;
    assign o_mc = r_mc;
    assign o_h  = r_h;
    assign o_w  = r_w;

endmodule

### hw/rtl/psa_msa_mac.sv
// Shared multiply-add unit that, while enabled, folds one index digit per cycle into an accumulator.
module psa_msa_mac #(
    parameter int ADD_W = 7
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_first,
    input  logic [psa_msa_pkg::IDX_W-1:0] i_seed,
    input  logic [psa_msa_pkg::SIZE_W-1:0] i_mult,
    input  logic [ADD_W-1:0]              i_add,
    output logic [psa_msa_pkg::IDX_W-1:0] o_acc
);

    logic [psa_msa_pkg::IDX_W-1:0] r_acc, n_acc, operand;

    assign operand = i_first ? i_seed : r_acc;
    assign n_acc   = psa_msa_pkg::IDX_W'(operand * psa_msa_pkg::IDX_W'(i_mult))
                   + psa_msa_pkg::IDX_W'(i_add);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

### dv/psa_msa_checker.sv
// Checker that predicts the scatter address of each mask element and compares the results.
module psa_msa_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psa_msa_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            pready,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [psa_msa_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic                            m_axis_tlast,
    input  logic [0:0]                      m_axis_tuser,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import psa_msa_pkg::*;

    localparam int MAX_FEATURE = 64;
    localparam int MAX_BATCH   = 64;
    localparam int MAX_MASK    = 127;
    localparam int DATA_WIDTH  = 32;

    typedef struct packed {
        logic [VAL_W-1:0] value_out;
        logic [IDX_W-1:0] src_index;
        logic [DST_W-1:0] dst_index;
        logic             in_window;
        logic             last;
    } t_scatter;

    logic              cfg_mode;
    logic [SIZE_W-1:0] cfg_batch;
    logic [SIZE_W-1:0] cfg_frows;
    logic [SIZE_W-1:0] cfg_fcols;
    logic [SIZE_W-1:0] cfg_mrows;
    logic [SIZE_W-1:0] cfg_mcols;
    logic [HALF_W-1:0] cfg_hrows;
    logic [HALF_W-1:0] cfg_hcols;

    logic [5:0] pos_batch;
    logic [6:0] pos_mrow;
    logic [6:0] pos_mcol;
    logic [5:0] pos_prow;
    logic [5:0] pos_pcol;

    t_scatter scatter_q[$];
    t_scatter got;
    t_scatter want;
    int       fail_count;

    function automatic longint unsigned clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic t_scatter predict_scatter(input logic [31:0] v);
        t_scatter          r;
        longint unsigned   nb, fh, fw, mh, mw;
        longint unsigned   n, mr, mc, h, w, hr, hc;
        longint unsigned   sr, sc, row, col, plane, src, dst, dmask;
        bit                in_win;
        nb = clamp_size(cfg_batch, MAX_BATCH);
        fh = clamp_size(cfg_frows, MAX_FEATURE);
        fw = clamp_size(cfg_fcols, MAX_FEATURE);
        mh = clamp_size(cfg_mrows, MAX_MASK);
        mw = clamp_size(cfg_mcols, MAX_MASK);
        n  = pos_batch;
        mr = pos_mrow;
        mc = pos_mcol;
        h  = pos_prow;
        w  = pos_pcol;
        hr = cfg_hrows;
        hc = cfg_hcols;
        sr = mr + h;
        sc = mc + w;
        in_win = (sr >= hr) && (sr - hr < fh) && (sc >= hc) && (sc - hc < fw);
        src = (((n * mh * mw + mr * mw + mc) * fh + h) * fw + w);
        dst = 0;
        if (in_win) begin
            row   = sr - hr;
            col   = sc - hc;
            plane = fh * fw;
            if (cfg_mode == 1'b0) begin
                dst = (n * plane + row * fw + col) * plane + h * fw + w;
            end else begin
                dst = (n * plane + h * fw + w) * plane + row * fw + col;
            end
        end
        dmask = (64'd1 << DATA_WIDTH) - 1;
        r.value_out = in_win ? VAL_W'(longint'(v) & dmask) : '0;
        r.src_index = src[IDX_W-1:0];
        r.dst_index = dst[DST_W-1:0];
        r.in_window = in_win;
        r.last      = (n + 1 >= nb) && (mr + 1 >= mh) && (mc + 1 >= mw) &&
                      (h + 1 >= fh) && (w + 1 >= fw);

        if (w + 1 >= fw) begin
            pos_pcol = '0;
            if (h + 1 >= fh) begin
                pos_prow = '0;
                if (mc + 1 >= mw) begin
                    pos_mcol = '0;
                    if (mr + 1 >= mh) begin
                        pos_mrow  = '0;
                        pos_batch = (n + 1 >= nb) ? '0 : pos_batch + 1'b1;
                    end else begin
                        pos_mrow = pos_mrow + 1'b1;
                    end
                end else begin
                    pos_mcol = pos_mcol + 1'b1;
                end
            end else begin
                pos_prow = pos_prow + 1'b1;
            end
        end else begin
            pos_pcol = pos_pcol + 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_mode   = 1'b0;
            cfg_batch  = 7'd1;
            cfg_frows  = 7'd1;
            cfg_fcols  = 7'd1;
            cfg_mrows  = 7'd1;
            cfg_mcols  = 7'd1;
            cfg_hrows  = '0;
            cfg_hcols  = '0;
            pos_batch  = '0;
            pos_mrow   = '0;
            pos_mcol   = '0;
            pos_prow   = '0;
            pos_pcol   = '0;
            scatter_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.value_out = m_axis_tdata[31:0];
                got.src_index = m_axis_tdata[63:32];
                got.dst_index = m_axis_tdata[93:64];
                got.in_window = m_axis_tuser[0];
                got.last      = m_axis_tlast;
                if (scatter_q.size() == 0) begin
                    $error("Result transfer with no element pending: tdata %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = scatter_q.pop_front();
                    if (got.value_out !== want.value_out) begin
                        $error("value_out: expected %h, actual %h", want.value_out,
                               got.value_out);
                        fail_count++;
                    end
                    if (got.src_index !== want.src_index) begin
                        $error("src_index: expected %0d, actual %0d", want.src_index,
                               got.src_index);
                        fail_count++;
                    end
                    if (got.dst_index !== want.dst_index) begin
                        $error("dst_index: expected %0d, actual %0d", want.dst_index,
                               got.dst_index);
                        fail_count++;
                    end
                    if (got.in_window !== want.in_window) begin
                        $error("in_window: expected %b, actual %b", want.in_window,
                               got.in_window);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                scatter_q.push_back(predict_scatter(s_axis_tdata));
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_MODE:           cfg_mode  = pwdata[0];
                    REG_BATCH_COUNT:    cfg_batch = pwdata[SIZE_W-1:0];
                    REG_FEATURE_ROWS:   cfg_frows = pwdata[SIZE_W-1:0];
                    REG_FEATURE_COLS:   cfg_fcols = pwdata[SIZE_W-1:0];
                    REG_MASK_ROWS:      cfg_mrows = pwdata[SIZE_W-1:0];
                    REG_MASK_COLS:      cfg_mcols = pwdata[SIZE_W-1:0];
                    REG_HALF_MASK_ROWS: cfg_hrows = pwdata[HALF_W-1:0];
                    REG_HALF_MASK_COLS: cfg_hcols = pwdata[HALF_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= scatter_q.size();
        o_fail_count <= fail_count;
    end

endmodule

### dv/tb.sv
// Testbench top of the mask scatter address generator: stimulus, watchdog and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psa_msa_pkg::*;

    localparam int ITEM_TARGET    = 1300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;   // value[31:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [TDATA_W-1:0]   m_axis_tdata;   // value_out[31:0], src_index[63:32], dst_index[93:64]
    logic                 m_axis_tlast;
    logic [0:0]           m_axis_tuser;   // in_window[0]

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int items_sent  = 0;
    bit burst       = 1'b0;

    always #6 i_clk = ~i_clk;

    psa_mask_scatter_address dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    psa_msa_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [31:0] rand_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    function automatic int extreme_size();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 127;
            2:       return 64;
            default: return $urandom_range(1, 127);
        endcase
    endfunction

    function automatic int extreme_half();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 63;
            default: return $urandom_range(0, 63);
        endcase
    endfunction

    task automatic apb_write(input t_reg_idx idx, input int value, input int width);
        logic [31:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? ($urandom() << width) : 32'd0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= junk | value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input int md, input int nb, input int fr, input int fc,
                              input int mr, input int mc, input int hr, input int hc);
        apb_write(REG_MODE, md, 1);
        apb_write(REG_BATCH_COUNT, nb, SIZE_W);
        apb_write(REG_FEATURE_ROWS, fr, SIZE_W);
        apb_write(REG_FEATURE_COLS, fc, SIZE_W);
        apb_write(REG_MASK_ROWS, mr, SIZE_W);
        apb_write(REG_MASK_COLS, mc, SIZE_W);
        apb_write(REG_HALF_MASK_ROWS, hr, HALF_W);
        apb_write(REG_HALF_MASK_COLS, hc, HALF_W);
    endtask

    task automatic send_value(input logic [31:0] v);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= v;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic send_values(input int count);
        for (int i = 0; i < count; i++) send_value(rand_value());
        finish_phase();
    endtask

    initial begin
        int run;
        int stall;
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            m_axis_tready <= 1'b1;
            repeat (run) @(negedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int kind, md, nb, fr, fc, mr, mc, hr, hc, size, count;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset sizes: every element is the last one of a one-element tensor.
        send_value(32'h0000_0000);
        send_value(32'hFFFF_FFFF);
        finish_phase();

        // Distribute mode, zero counts acting as one, part of the window outside the map.
        set_config(1, 0, 0, 2, 1, 3, 0, 1);
        send_values(6);

        // Sizes above the maximum saturate; offsets at their largest value.
        set_config(0, 127, 127, 64, 127, 127, 63, 63);
        send_values(4);

        // Limits lowered below the running counters force a wrap with carry.
        set_config(0, 1, 1, 1, 1, 1, 0, 0);
        send_values(3);

        set_config(1, 2, 2, 2, 3, 3, 1, 1);
        send_values(8);

        while (items_sent < ITEM_TARGET) begin
            kind  = $urandom_range(0, 9);
            burst = ($urandom_range(0, 3) == 0);
            md    = $urandom_range(0, 1);
            if (kind < 7) begin
                nb = $urandom_range(1, 3);
                fr = $urandom_range(1, 4);
                fc = $urandom_range(1, 4);
                mr = $urandom_range(1, 5);
                mc = $urandom_range(1, 5);
                hr = $urandom_range(0, 5);
                hc = $urandom_range(0, 5);
                size = nb * fr * fc * mr * mc;
                if (size <= 100) count = size * $urandom_range(1, 2);
                else count = $urandom_range(20, 100);
                if ($urandom_range(0, 3) == 0) count = $urandom_range(1, size);
            end else if (kind == 7) begin
                nb = 1;
                mr = 1;
                mc = 1;
                case ($urandom_range(0, 2))
                    0:       begin nb = $urandom_range(2, 64);  count = $urandom_range(1, nb); end
                    1:       begin mr = $urandom_range(2, 127); count = $urandom_range(1, mr); end
                    default: begin mc = $urandom_range(2, 127); count = $urandom_range(1, mc); end
                endcase
                fr = 1;
                fc = 1;
                hr = 0;
                hc = 0;
            end else begin
                nb = extreme_size();
                fr = extreme_size();
                fc = extreme_size();
                mr = extreme_size();
                mc = extreme_size();
                hr = extreme_half();
                hc = extreme_half();
                count = $urandom_range(5, 40);
            end
            set_config(md, nb, fr, fc, mr, mc, hr, hc);
            send_values(count);
        end

        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
